>>> sv/sacl_pkg.sv
// Shared types and constants for the set-associative cache lookup block.
// No dependencies; imported by the top level and its checker.
package sacl_pkg;

  localparam int ADDR_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int WAYO_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [STAMP_W-1:0] stamp;
  } in_t;

  typedef struct packed {
    logic              was_hit;
    logic              was_evicted;
    logic [WAYO_W-1:0] way_used;
    logic [CNT_W-1:0]  total_hits;
    logic [CNT_W-1:0]  total_misses;
    logic [CNT_W-1:0]  total_evictions;
  } out_t;

endpackage

>>> sv/set_assoc_cache_lookup_replace_top.sv
// Set-associative tag store with LRU / FIFO replacement and saturating counters.
// Depends on sacl_pkg (in_t, out_t, widths, policy codes).
//
// Usage:
//   Input: drive in_data (address, stamp) with start high; the transfer happens at a
//   rising edge where start is high and busy is low.
//   Output: one result per input, shown on out_data for exactly one cycle with
//   out_strobe high. Nothing can hold it off; the receiver must take it then.
//   Config: cfg_we with cfg_wdata writes the replacement policy (0 FIFO, 1 LRU);
//   write only while idle.
// Flow:
//   The set row is read from the tag memory at the transfer edge; in the lookup phase
//   the updated row is written back and the result registered and strobed, through
//   the single read/write port pair of that memory. busy stays high meanwhile, so a
//   new access is taken only after the last one is written back.
// Reset:
//   rst_n low clears control state, counters, and sets policy to LRU. After
//   reset a clearing pass writes empty rows to all 2^INDEX_BITS sets, one per
//   cycle; busy stays high until that pass is done.
module set_assoc_cache_lookup_replace_top
  import sacl_pkg::*;
#(
  parameter int INDEX_BITS  = 4,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int NUM_SETS = 1 << INDEX_BITS;
  localparam int TAG_W    = ADDR_W - INDEX_BITS - OFFSET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TREE_N   = 1 << $clog2(WAYS);

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_LOOK = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] use_s;
    logic [STAMP_W-1:0] fill_s;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  row_t mem [NUM_SETS];

  logic                  phase_r;
  logic                  clr_active_r;
  logic [INDEX_BITS-1:0] clr_idx_r;
  logic                  policy_r;
  row_t                  rd_row_r;
  logic [INDEX_BITS-1:0] set_r;
  logic [TAG_W-1:0]      tag_r;
  logic [STAMP_W-1:0]    now_r;
  logic [CNT_W-1:0]      hits_r, misses_r, evicts_r;
  logic [CNT_W-1:0]      hits_nxt, misses_nxt, evicts_nxt;
  logic                  out_strobe_r;
  out_t                  out_r;

  logic                  accept;
  logic [INDEX_BITS-1:0] in_set;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             any_inv;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] vic_way;
  logic [WAY_W-1:0] sel_way;
  logic [WAY_W+1:0] way_ext;
  row_t             row_nxt;

  logic [STAMP_W-1:0] nd_stamp [1:2*TREE_N-1];
  logic [WAY_W-1:0]   nd_idx   [1:2*TREE_N-1];
  logic               nd_ok    [1:2*TREE_N-1];

  assign busy   = clr_active_r | (phase_r == PH_LOOK);
  assign accept = start & ~busy;
  assign in_set = in_data.address[OFFSET_BITS +: INDEX_BITS];

  // hit and first-invalid search, highest way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row_r[w].valid && (rd_row_r[w].tag == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_row_r[w].valid) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // victim tree: smaller stamp wins; on a tie way 0 first, then the higher way
  always_comb begin
    logic b_better;
    for (int i = 0; i < TREE_N; i++) begin
      if (i < WAYS) begin
        nd_ok[TREE_N+i]    = 1'b1;
        nd_stamp[TREE_N+i] = (policy_r == POLICY_LRU) ? rd_row_r[i].use_s
                                                      : rd_row_r[i].fill_s;
      end else begin
        nd_ok[TREE_N+i]    = 1'b0;
        nd_stamp[TREE_N+i] = '0;
      end
      nd_idx[TREE_N+i] = WAY_W'(i);
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      b_better = nd_ok[2*n+1] &&
                 (!nd_ok[2*n] ||
                  (nd_stamp[2*n+1] < nd_stamp[2*n]) ||
                  ((nd_stamp[2*n+1] == nd_stamp[2*n]) &&
                   ((nd_idx[2*n+1] == '0) ||
                    ((nd_idx[2*n] != '0) && (nd_idx[2*n+1] > nd_idx[2*n])))));
      nd_ok[n]    = nd_ok[2*n] | nd_ok[2*n+1];
      nd_stamp[n] = b_better ? nd_stamp[2*n+1] : nd_stamp[2*n];
      nd_idx[n]   = b_better ? nd_idx[2*n+1]   : nd_idx[2*n];
    end
    vic_way = nd_idx[1];
  end

  always_comb begin
    sel_way = hit ? hit_way : (any_inv ? inv_way : vic_way);
    way_ext = {2'b00, sel_way};
    row_nxt = rd_row_r;
    if (hit) begin
      row_nxt[sel_way].use_s = now_r;
    end else begin
      row_nxt[sel_way].valid  = 1'b1;
      row_nxt[sel_way].tag    = tag_r;
      row_nxt[sel_way].use_s  = now_r;
      row_nxt[sel_way].fill_s = now_r;
    end
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (hit) begin
      if (hits_r != CNT_MAX) hits_nxt = hits_r + 1'b1;
    end else begin
      if (misses_r != CNT_MAX) misses_nxt = misses_r + 1'b1;
      if (!any_inv && (evicts_r != CNT_MAX)) evicts_nxt = evicts_r + 1'b1;
    end
  end

  // tag memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_idx_r] <= '0;
    end else if (phase_r == PH_LOOK) begin
      mem[set_r] <= row_nxt;
    end
    if (accept) begin
      rd_row_r <= mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r <= in_set;
      tag_r <= in_data.address[ADDR_W-1 -: TAG_W];
      now_r <= in_data.stamp;
    end
    if (phase_r == PH_LOOK) begin
      out_r.was_hit         <= hit;
      out_r.was_evicted     <= ~hit & ~any_inv;
      out_r.way_used        <= way_ext[WAYO_W-1:0];
      out_r.total_hits      <= hits_nxt;
      out_r.total_misses    <= misses_nxt;
      out_r.total_evictions <= evicts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      policy_r     <= POLICY_LRU;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) policy_r <= cfg_wdata;
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) clr_active_r <= 1'b0;
      end
      out_strobe_r <= (phase_r == PH_LOOK);
      case (phase_r)
        PH_IDLE: begin
          if (accept) phase_r <= PH_LOOK;
        end
        PH_LOOK: begin
          hits_r   <= hits_nxt;
          misses_r <= misses_nxt;
          evicts_r <= evicts_nxt;
          phase_r  <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

>>> sv/sacl_check.sv
// Port-level checker for the cache lookup top level, bound into it below.
// Depends on sacl_pkg for the out_t payload type.
module sacl_check
  import sacl_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_data
);

  // every result traces back to an earlier input transfer
  a_strobe_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result strobe without a matching input transfer");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.was_evicted) |-> !out_data.was_hit)
    else $error("eviction reported on a hit");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.total_evictions <= out_data.total_misses))
    else $error("eviction count exceeds miss count");

endmodule

bind set_assoc_cache_lookup_replace_top sacl_check u_sacl_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

>>> dv/set_assoc_cache_lookup_replace_top_tb.sv
// Testbench for set_assoc_cache_lookup_replace_top: directed and random cache accesses,
// each result checked against a predictor of the tag store. Depends on sacl_pkg.
`timescale 1ns / 100ps

module set_assoc_cache_lookup_replace_top_tb;
  import sacl_pkg::*;

  localparam int INDEX_BITS  = 4;
  localparam int WAYS        = 4;
  localparam int OFFSET_BITS = 4;
  localparam int NUM_SETS    = 1 << INDEX_BITS;
  localparam int TAG_W       = ADDR_W - INDEX_BITS - OFFSET_BITS;
  localparam int RAND_ITEMS  = 1100;
  localparam int CHUNKS      = 6;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_strobe;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  logic [TAG_W-1:0]   tag_pool [8];
  logic [STAMP_W-1:0] now_stamp = '0;

  always #5 clk = ~clk;

  set_assoc_cache_lookup_replace_top #(
    .INDEX_BITS(INDEX_BITS),
    .WAYS(WAYS),
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Tag store predictor plus queue of expected lookup results.
  class cache_scoreboard;
    bit                 line_vld  [NUM_SETS*WAYS];
    bit [TAG_W-1:0]     line_tag  [NUM_SETS*WAYS];
    bit [STAMP_W-1:0]   last_use  [NUM_SETS*WAYS];
    bit [STAMP_W-1:0]   fill_time [NUM_SETS*WAYS];
    bit [CNT_W-1:0]     hit_cnt, miss_cnt, evict_cnt;
    logic               policy;
    out_t               lookup_q [$];
    int                 mismatches;

    function new();
      policy     = POLICY_LRU;
      hit_cnt    = '0;
      miss_cnt   = '0;
      evict_cnt  = '0;
      mismatches = 0;
    endfunction

    function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function bit [STAMP_W-1:0] age_of(int e);
      return (policy == POLICY_LRU) ? last_use[e] : fill_time[e];
    endfunction

    function void note_access(in_t acc);
      int             base, way, victim;
      bit             found;
      bit [TAG_W-1:0] tag;
      out_t           res;
      base  = int'(acc.address[OFFSET_BITS +: INDEX_BITS]) * WAYS;
      tag   = acc.address[ADDR_W-1 -: TAG_W];
      found = 1'b0;
      way   = 0;
      res   = '0;
      for (int w = WAYS - 1; w >= 0 && !found; w--) begin
        if (line_vld[base+w] && line_tag[base+w] == tag) begin
          found = 1'b1;
          way   = w;
        end
      end
      if (found) begin
        res.was_hit      = 1'b1;
        last_use[base+way] = acc.stamp;
        hit_cnt = bump(hit_cnt);
      end else begin
        miss_cnt = bump(miss_cnt);
        for (int w = WAYS - 1; w >= 0 && !found; w--) begin
          if (!line_vld[base+w]) begin
            found = 1'b1;
            way   = w;
          end
        end
        if (!found) begin
          // way 0 is the starting candidate; move only on strictly older
          victim = 0;
          for (int w = WAYS - 1; w >= 0; w--) begin
            if (age_of(base + victim) > age_of(base + w)) victim = w;
          end
          way = victim;
          res.was_evicted = 1'b1;
          evict_cnt = bump(evict_cnt);
        end
        line_vld[base+way]  = 1'b1;
        line_tag[base+way]  = tag;
        last_use[base+way]  = acc.stamp;
        fill_time[base+way] = acc.stamp;
      end
      res.way_used        = way[WAYO_W-1:0];
      res.total_hits      = hit_cnt;
      res.total_misses    = miss_cnt;
      res.total_evictions = evict_cnt;
      lookup_q.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no access pending: hit=%0b ev=%0b way=%0d", $realtime,
                   got.was_hit, got.was_evicted, got.way_used);
        return;
      end
      exp = lookup_q.pop_front();
      if (got.was_hit !== exp.was_hit || got.was_evicted !== exp.was_evicted ||
          got.way_used !== exp.way_used || got.total_hits !== exp.total_hits ||
          got.total_misses !== exp.total_misses ||
          got.total_evictions !== exp.total_evictions) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: exp hit=%0b ev=%0b way=%0d hits=%0d misses=%0d evicts=%0d",
                   $realtime, exp.was_hit, exp.was_evicted, exp.way_used,
                   exp.total_hits, exp.total_misses, exp.total_evictions);
          $display("%0t: got hit=%0b ev=%0b way=%0d hits=%0d misses=%0d evicts=%0d",
                   $realtime, got.was_hit, got.was_evicted, got.way_used,
                   got.total_hits, got.total_misses, got.total_evictions);
        end
      end
    endfunction

    function int pending();
      return lookup_q.size();
    endfunction
  endclass

  cache_scoreboard sb = new();

  // Results from earlier accesses are checked before the access of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) sb.check_result(out_data);
      if (start === 1'b1 && busy === 1'b0) sb.note_access(in_data);
    end
  end

  function automatic logic [ADDR_W-1:0] mk_addr(logic [TAG_W-1:0] tag,
                                                logic [INDEX_BITS-1:0] set_idx,
                                                logic [OFFSET_BITS-1:0] offs);
    return {tag, set_idx, offs};
  endfunction

  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [STAMP_W-1:0] stamp);
    start   <= 1'b1;
    in_data <= {addr, stamp};
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Each cycle before the next item the sender holds off with the given odds.
  task automatic sender_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Settle everything in flight, then write the policy.
  task automatic write_policy(input logic pol);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.policy = pol;
  endtask

  // Mostly a small tag pool over a few hot sets, so hits and evictions dominate.
  task automatic send_random;
    logic [ADDR_W-1:0]     addr;
    logic [INDEX_BITS-1:0] set_idx;
    if ($urandom_range(0, 99) < 70) set_idx = INDEX_BITS'($urandom_range(0, 3));
    else set_idx = INDEX_BITS'($urandom);
    if ($urandom_range(0, 99) < 85)
      addr = mk_addr(tag_pool[$urandom_range(0, 7)], set_idx, OFFSET_BITS'($urandom));
    else
      addr = {$urandom, $urandom};
    now_stamp = now_stamp + STAMP_W'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 10) send_access(addr, $urandom);
    else send_access(addr, now_stamp);
  endtask

  initial begin
    int chunk, idle_pct;
    for (int k = 0; k < 8; k++) tag_pool[k] = TAG_W'({$urandom, $urandom});
    tag_pool[0] = '0;
    tag_pool[7] = '1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Address extremes; all-ones hits again through another offset.
    send_access('0, '0);
    send_access('1, '1);
    send_access({{(ADDR_W-OFFSET_BITS){1'b1}}, {OFFSET_BITS{1'b0}}}, 32'd1);
    // Fill set 5 with equal stamps: ways fill 3 down to 0.
    for (int k = 1; k <= 4; k++) send_access(mk_addr(TAG_W'(k), 4'd5, 4'd0), 32'd10);
    // LRU, all tied: way 0 is kept as victim.
    send_access(mk_addr(TAG_W'(5), 4'd5, 4'd3), 32'd20);
    // Way 0 now newest: the highest-index oldest way goes.
    send_access(mk_addr(TAG_W'(6), 4'd5, 4'd7), 32'd30);
    // Hit refresh with a stamp that has its top bit set (unsigned compare).
    send_access(mk_addr(TAG_W'(2), 4'd5, 4'd15), 32'h8000_0000);
    send_access(mk_addr(TAG_W'(7), 4'd5, 4'd1), 32'd40);
    write_policy(POLICY_FIFO);
    send_access(mk_addr(TAG_W'(8), 4'd5, 4'd2), 32'd50);
    send_access(mk_addr(TAG_W'(5), 4'd5, 4'd2), 32'd60);
    send_access(mk_addr(TAG_W'(9), 4'd5, 4'd2), 32'd70);
    send_access(mk_addr({1'b1, {(TAG_W-1){1'b0}}}, 4'd5, 4'd9), 32'hFFFF_FFFF);
    send_access(mk_addr(TAG_W'(3), 4'd5, 4'd0), 32'd0);
    write_policy(POLICY_LRU);
    send_access(mk_addr({1'b1, {(TAG_W-1){1'b0}}}, 4'd5, 4'd4), 32'd80);
    send_access(mk_addr(TAG_W'(10), 4'd5, 4'd0), 32'd90);
    send_access(mk_addr('1, 4'd0, 4'd0), 32'd100);
    now_stamp = 32'd200;

    for (int i = 0; i < RAND_ITEMS; i++) begin
      chunk = i * CHUNKS / RAND_ITEMS;
      if (i == 0 || (i - 1) * CHUNKS / RAND_ITEMS != chunk)
        write_policy((chunk % 2 == 0) ? POLICY_LRU : POLICY_FIFO);
      case (chunk / 2)
        0:       idle_pct = 17;
        1:       idle_pct = 85;
        default: idle_pct = 0;
      endcase
      send_random();
      sender_gap(idle_pct);
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
